/* src/mep_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time pixel block.
`timescale 1ns / 1ps
package mep_pkg;
  localparam int FracBits = 24;
  localparam int ValueWidth = 40;
  localparam int CoordWidth = 12;
  localparam int ProdWidth = 2 * ValueWidth;
  localparam logic signed [ValueWidth-1:0] Vmax = {1'b0, {(ValueWidth-1){1'b1}}};

  localparam logic [2:0] RegCenterCol = 3'd0;
  localparam logic [2:0] RegCenterRow = 3'd1;
  localparam logic [2:0] RegStepSize = 3'd2;
  localparam logic [2:0] RegEscapeLimit = 3'd3;
  localparam logic [2:0] RegInnerLimit = 3'd4;
  localparam logic [2:0] RegMaxIterations = 3'd5;

  localparam logic [1:0] ClassBlack = 2'd0;
  localparam logic [1:0] ClassPink = 2'd1;
  localparam logic [1:0] ClassBlue = 2'd2;

  typedef struct packed {
    logic [CoordWidth-1:0] pixel_col;
    logic [CoordWidth-1:0] pixel_row;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] color_class;
    logic [23:0] pixel_rgb;
    logic [16:0] iteration_count;
  } out_beat_t;

  // Mapped point handed from the front to the iteration engine.
  typedef struct packed {
    logic signed [ValueWidth-1:0] cr;
    logic signed [ValueWidth-1:0] ci;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_CHECK, ST_UPDATE, ST_DONE
  } iter_state_t;

  // Saturate a wide signed value to +-Vmax.
  function automatic logic signed [ValueWidth-1:0] sat_wide(
      input logic signed [ValueWidth+1:0] v);
    logic signed [ValueWidth+1:0] hi;
    logic signed [ValueWidth+1:0] lo;
    hi = {{2{1'b0}}, Vmax};
    lo = -hi;
    if (v > hi) return Vmax;
    else if (v < lo) return -Vmax;
    else return v[ValueWidth-1:0];
  endfunction

  function automatic logic signed [ValueWidth-1:0] sat_add(
      input logic signed [ValueWidth-1:0] a, input logic signed [ValueWidth-1:0] b);
    return sat_wide({{2{a[ValueWidth-1]}}, a} + {{2{b[ValueWidth-1]}}, b});
  endfunction

  function automatic logic [ValueWidth-1:0] abs_val(input logic signed [ValueWidth-1:0] a);
    return a[ValueWidth-1] ? ValueWidth'(-a) : a;
  endfunction

  // Truncate a product magnitude by FracBits, saturate and apply the sign.
  function automatic logic signed [ValueWidth-1:0] fx_scale(
      input logic [ProdWidth-1:0] mag, input logic neg);
    logic [ProdWidth-1:0] sh;
    logic [ValueWidth-1:0] m;
    sh = mag >> FracBits;
    if (sh > ProdWidth'(Vmax)) m = Vmax;
    else m = sh[ValueWidth-1:0];
    return neg ? ValueWidth'(-m) : m;
  endfunction
endpackage

/* src/mep_front.sv */
// Front: accepts a pixel, maps it to a complex point and queues it.
`timescale 1ns / 1ps
module mep_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  mep_pkg::in_beat_t in_beat,
  input  logic [mep_pkg::CoordWidth-1:0] center_col,
  input  logic [mep_pkg::CoordWidth-1:0] center_row,
  input  logic [23:0] step_size,
  output logic q_valid,
  input  logic q_take,
  output mep_pkg::point_t q_point
);
  localparam int DiffW = mep_pkg::CoordWidth + 1;
  localparam int MulW = 24 + DiffW;

  // Stage: mapped point registers (one multiply each)
  logic stg_valid;
  mep_pkg::point_t stg_point;
  logic signed [DiffW-1:0] dcol;
  logic signed [DiffW-1:0] drow;
  logic signed [MulW-1:0] pcol;
  logic signed [MulW-1:0] prow;
  logic signed [mep_pkg::ValueWidth+1:0] pcol_x;
  logic signed [mep_pkg::ValueWidth+1:0] prow_x;
  logic stg_take;

  // Two-entry queue to the engine
  mep_pkg::point_t qmem [2];
  logic [1:0] qcount;
  logic qrd;
  logic qwr;

  assign dcol = $signed({1'b0, in_beat.pixel_col}) - $signed({1'b0, center_col});
  assign drow = $signed({1'b0, in_beat.pixel_row}) - $signed({1'b0, center_row});
  assign pcol = $signed({1'b0, step_size}) * dcol;
  assign prow = $signed({1'b0, step_size}) * drow;
  assign pcol_x = (mep_pkg::ValueWidth + 2)'(pcol);
  assign prow_x = (mep_pkg::ValueWidth + 2)'(prow);

  assign stg_take = stg_valid && (qcount != 2'd2);
  assign full = stg_valid && !stg_take;

  // Hold the mapped point until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (push && !full) begin
      stg_valid <= 1'b1;
    end else if (stg_take) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      stg_point.cr <= mep_pkg::sat_wide(pcol_x);
      stg_point.ci <= mep_pkg::sat_wide(prow_x);
    end
  end

  assign q_valid = (qcount != 2'd0);
  assign q_point = qmem[qrd];

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= 2'd0;
      qrd <= 1'b0;
      qwr <= 1'b0;
    end else begin
      if (stg_take) qwr <= ~qwr;
      if (q_take && q_valid) qrd <= ~qrd;
      qcount <= qcount + {1'b0, stg_take} - {1'b0, q_take && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) qmem[qwr] <= stg_point;
  end
endmodule

/* src/mep_engine.sv */
// Back: iterates z = z^2 + c for one point and classifies the pixel.
`timescale 1ns / 1ps
module mep_engine (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  mep_pkg::point_t q_point,
  input  logic [30:0] escape_limit,
  input  logic [30:0] inner_limit,
  input  logic [15:0] max_iterations,
  output logic empty,
  input  logic pop,
  output mep_pkg::out_beat_t out_beat
);
  localparam int VW = mep_pkg::ValueWidth;
  localparam int PW = mep_pkg::ProdWidth;
  localparam int HW = mep_pkg::ValueWidth / 2;
  localparam int PartW = VW + HW;

  mep_pkg::iter_state_t state;
  mep_pkg::iter_state_t state_next;
  mep_pkg::point_t c;
  logic signed [VW-1:0] x;
  logic signed [VW-1:0] y;
  logic signed [VW-1:0] xx;
  logic signed [VW-1:0] yy;
  logic signed [VW-1:0] xy;
  logic signed [VW-1:0] r;
  logic signed [VW-1:0] xx_now;
  logic signed [VW-1:0] yy_now;
  logic signed [VW-1:0] r_now;
  logic [16:0] n;
  logic [PW-1:0] m_xx;
  logic [PW-1:0] m_yy;
  logic [PW-1:0] m_xy;
  logic [VW-1:0] ax;
  logic [VW-1:0] ay;
  logic [HW-1:0] ax_part;
  logic [HW-1:0] ay_part;
  logic [PartW-1:0] p_xx;
  logic [PartW-1:0] p_yy;
  logic [PartW-1:0] p_xy;
  logic stop;
  logic load;
  logic finish;
  logic [16:0] max_ext;

  assign ax = mep_pkg::abs_val(x);
  assign ay = mep_pkg::abs_val(y);
  assign max_ext = {1'b0, max_iterations};

  // Squared magnitude of the current z, straight from the finished products
  assign xx_now = mep_pkg::fx_scale(m_xx, 1'b0);
  assign yy_now = mep_pkg::fx_scale(m_yy, 1'b0);
  assign r_now = mep_pkg::sat_add(xx_now, yy_now);
  assign stop = (r_now[VW-1] ||
                 ({1'b0, r_now[VW-2:0]} > {{(VW-31){1'b0}}, escape_limit}))
                || (n > max_ext);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mep_pkg::ST_IDLE:   if (q_valid) state_next = mep_pkg::ST_MUL_LO;
      mep_pkg::ST_MUL_LO: state_next = mep_pkg::ST_MUL_HI;
      mep_pkg::ST_MUL_HI: state_next = mep_pkg::ST_CHECK;
      mep_pkg::ST_CHECK:  state_next = stop ? mep_pkg::ST_DONE : mep_pkg::ST_UPDATE;
      mep_pkg::ST_UPDATE: state_next = mep_pkg::ST_MUL_LO;
      mep_pkg::ST_DONE:   if (empty || pop) state_next = mep_pkg::ST_IDLE;
      default:            state_next = mep_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    load = 1'b0;
    finish = 1'b0;
    unique case (state)
      mep_pkg::ST_IDLE: load = q_valid;
      mep_pkg::ST_DONE: finish = empty || pop;
      default: ;
    endcase
  end
  assign q_take = load;

  always_ff @(posedge clk) begin
    if (rst) state <= mep_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Pick the low or high half of the second operand
  assign ax_part = (state == mep_pkg::ST_MUL_HI) ? ax[VW-1:HW] : ax[HW-1:0];
  assign ay_part = (state == mep_pkg::ST_MUL_HI) ? ay[VW-1:HW] : ay[HW-1:0];
  assign p_xx = PartW'(ax) * PartW'(ax_part);
  assign p_yy = PartW'(ay) * PartW'(ay_part);
  assign p_xy = PartW'(ax) * PartW'(ay_part);

  // Multiply magnitudes: low half in ST_MUL_LO, then add the shifted high half in ST_MUL_HI
  always_ff @(posedge clk) begin
    if (state == mep_pkg::ST_MUL_LO) begin
      m_xx <= PW'(p_xx);
      m_yy <= PW'(p_yy);
      m_xy <= PW'(p_xy);
    end else if (state == mep_pkg::ST_MUL_HI) begin
      m_xx <= m_xx + (PW'(p_xx) << HW);
      m_yy <= m_yy + (PW'(p_yy) << HW);
      m_xy <= m_xy + (PW'(p_xy) << HW);
    end
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    if (load) begin
      c <= q_point;
      x <= '0;
      y <= '0;
      n <= '0;
    end else if (state == mep_pkg::ST_CHECK) begin
      xx <= xx_now;
      yy <= yy_now;
      xy <= mep_pkg::fx_scale(m_xy, x[VW-1] ^ y[VW-1]);
      r <= r_now;
    end else if (state == mep_pkg::ST_UPDATE) begin
      x <= mep_pkg::sat_add(mep_pkg::sat_add(xx, -yy), c.cr);
      y <= mep_pkg::sat_add(mep_pkg::sat_add(xy, xy), c.ci);
      n <= n + 17'd1;
    end
  end

  // Result register: one beat waits here while the next pixel is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (finish) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_beat.iteration_count <= n;
      if (n <= max_ext) begin
        out_beat.color_class <= mep_pkg::ClassBlack;
        out_beat.pixel_rgb <= 24'h000000;
      end else if ({1'b0, r[VW-2:0]} < {{(VW-31){1'b0}}, inner_limit}) begin
        out_beat.color_class <= mep_pkg::ClassPink;
        out_beat.pixel_rgb <= 24'hFF8080;
      end else begin
        out_beat.color_class <= mep_pkg::ClassBlue;
        out_beat.pixel_rgb <= 24'h0000FF;
      end
    end
  end
endmodule

/* src/mandelbrot_escape_time_pixel.sv */
// Top level: Mandelbrot escape-time pixel classifier.
// The engine takes one pixel at a time and runs n iterations (n up to max_iterations+1),
// each through ST_MUL_LO, ST_MUL_HI, ST_CHECK and ST_UPDATE; a last check goes to ST_DONE.
// The engine's squaring unit splits each product into two half-width multiplies,
// low half first, then the shifted high half.
// Reset: synchronous, active high; control and configuration registers take their defaults, queues empty.
`timescale 1ns / 1ps
module mandelbrot_escape_time_pixel (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  mep_pkg::in_beat_t in_data,
  output logic empty,
  input  logic pop,
  output mep_pkg::out_beat_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [30:0] cfg_data
);
  logic [11:0] center_col;
  logic [11:0] center_row;
  logic [23:0] step_size;
  logic [30:0] escape_limit;
  logic [30:0] inner_limit;
  logic [15:0] max_iterations;
  logic q_valid;
  logic q_take;
  mep_pkg::point_t q_point;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= 12'd500;
      center_row <= 12'd300;
      step_size <= 24'd83886;
      escape_limit <= 31'd167772160;
      inner_limit <= 31'd8388608;
      max_iterations <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        mep_pkg::RegCenterCol:     center_col <= cfg_data[11:0];
        mep_pkg::RegCenterRow:     center_row <= cfg_data[11:0];
        mep_pkg::RegStepSize:      step_size <= cfg_data[23:0];
        mep_pkg::RegEscapeLimit:   escape_limit <= cfg_data;
        mep_pkg::RegInnerLimit:    inner_limit <= cfg_data;
        mep_pkg::RegMaxIterations: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mep_front u_front (
    .clk, .rst, .push, .full, .in_beat(in_data),
    .center_col, .center_row, .step_size,
    .q_valid, .q_take, .q_point
  );

  mep_engine u_engine (
    .clk, .rst, .q_valid, .q_take, .q_point,
    .escape_limit, .inner_limit, .max_iterations,
    .empty, .pop, .out_beat(out_data)
  );

  // Checks
  a_take_valid: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("engine took from empty queue");
  a_class_rgb: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.color_class == mep_pkg::ClassBlack) |-> out_data.pixel_rgb == 24'h0)
    else $error("black pixel with color");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(!empty && !pop) && !$past(rst)) |-> $stable(out_data))
    else $error("result changed while waiting");
endmodule

/* tb/mandelbrot_escape_time_pixel_test.sv */
// Testbench for the Mandelbrot escape-time pixel classifier: directed and random pixels.
`timescale 1ns / 1ps
module mandelbrot_escape_time_pixel_test;
  localparam longint VLIM = (64'sd1 <<< (mep_pkg::ValueWidth - 1)) - 1;
  localparam int WATCHDOG_LIMIT = 2000000;

  // Register image used by the pixel predictor.
  typedef struct {
    logic [11:0] center_col;
    logic [11:0] center_row;
    logic [23:0] step_size;
    logic [30:0] escape_limit;
    logic [30:0] inner_limit;
    logic [15:0] max_iterations;
  } escape_regs_t;

  // Clamp to the signed value range.
  function automatic longint clamp_val(input longint v);
    if (v > VLIM) return VLIM;
    if (v < -VLIM) return -VLIM;
    return v;
  endfunction

  // Fixed-point multiply: truncate the magnitude, then clamp.
  function automatic longint fixed_mul(input longint a, input longint b);
    logic [127:0] prod;
    logic [127:0] mag;
    logic neg;
    longint m;
    neg = (a < 0) != (b < 0);
    prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    mag = prod >> mep_pkg::FracBits;
    m = (mag > 128'(VLIM)) ? VLIM : longint'(mag[63:0]);
    return neg ? -m : m;
  endfunction

  // Scoreboard of predicted pixel colors.
  class pixel_scoreboard;
    mep_pkg::out_beat_t pending_colors[$];
    escape_regs_t regs;
    int errors;

    function void reset_regs();
      regs.center_col = 500;
      regs.center_row = 300;
      regs.step_size = 83886;
      regs.escape_limit = 167772160;
      regs.inner_limit = 8388608;
      regs.max_iterations = 1000;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [30:0] val);
      case (idx)
        mep_pkg::RegCenterCol: regs.center_col = val[11:0];
        mep_pkg::RegCenterRow: regs.center_row = val[11:0];
        mep_pkg::RegStepSize: regs.step_size = val[23:0];
        mep_pkg::RegEscapeLimit: regs.escape_limit = val;
        mep_pkg::RegInnerLimit: regs.inner_limit = val;
        mep_pkg::RegMaxIterations: regs.max_iterations = val[15:0];
        default: ;
      endcase
    endfunction

    // Iterate the escape loop for one pixel and queue its color.
    function void note_pixel(input mep_pkg::in_beat_t px);
      longint cr, ci, x, y, r, xx, yy, xy;
      longint unsigned n;
      mep_pkg::out_beat_t res;
      cr = clamp_val(longint'(regs.step_size) *
                     (longint'(px.pixel_col) - longint'(regs.center_col)));
      ci = clamp_val(longint'(regs.step_size) *
                     (longint'(px.pixel_row) - longint'(regs.center_row)));
      x = 0;
      y = 0;
      n = 0;
      forever begin
        xx = fixed_mul(x, x);
        yy = fixed_mul(y, y);
        r = clamp_val(xx + yy);
        if (r > longint'(regs.escape_limit) || n > regs.max_iterations) break;
        xy = fixed_mul(x, y);
        x = clamp_val(clamp_val(xx - yy) + cr);
        y = clamp_val(clamp_val(xy + xy) + ci);
        n++;
      end
      if (n <= regs.max_iterations) begin
        res.color_class = mep_pkg::ClassBlack;
        res.pixel_rgb = 24'h000000;
      end else if (r < longint'(regs.inner_limit)) begin
        res.color_class = mep_pkg::ClassPink;
        res.pixel_rgb = 24'hFF8080;
      end else begin
        res.color_class = mep_pkg::ClassBlue;
        res.pixel_rgb = 24'h0000FF;
      end
      res.iteration_count = n[16:0];
      pending_colors.push_back(res);
    endfunction

    function void check_pixel(input mep_pkg::out_beat_t got);
      mep_pkg::out_beat_t exp_px;
      if (pending_colors.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      exp_px = pending_colors.pop_front();
      if (got.color_class !== exp_px.color_class) begin
        $error("color_class exp %0d got %0d", exp_px.color_class, got.color_class);
        errors++;
      end
      if (got.pixel_rgb !== exp_px.pixel_rgb) begin
        $error("pixel_rgb exp %h got %h", exp_px.pixel_rgb, got.pixel_rgb);
        errors++;
      end
      if (got.iteration_count !== exp_px.iteration_count) begin
        $error("iteration_count exp %0d got %0d", exp_px.iteration_count,
               got.iteration_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  mep_pkg::in_beat_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  mep_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  mandelbrot_escape_time_pixel u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check result beats and watch for progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_pixel(out_data);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (rst || hold_off) pop <= 1'b0;
    else pop <= ($urandom_range(0, 9) < 7);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel and hold it until accepted.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    mep_pkg::in_beat_t px;
    px.pixel_col = col;
    px.pixel_row = row;
    push <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic send_burst(input int count, input bit burst_mode);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_mode && left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        left = $urandom_range(1, 20);
      end
      send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      left--;
    end
  endtask

  // Drain expected results, then let the engine settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_colors.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Keep pixels near the center so the iteration counts stay moderate.
  task automatic send_near(input int count, input int spread);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      send_pixel(12'(int'(sb.regs.center_col) + $urandom_range(0, 2 * spread) - spread),
                 12'(int'(sb.regs.center_row) + $urandom_range(0, 2 * spread) - spread));
    end
  endtask

  initial begin
    sb.reset_regs();
    sb.errors = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners, center and classes at default settings, low limit.
    write_reg(mep_pkg::RegMaxIterations, 31'd60);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd500, 12'd300);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'd450, 12'd320);
    send_pixel(12'd520, 12'd300);
    send_pixel(12'd395, 12'd300);
    drain();

    // Zero limit, maximum step and window extremes: saturating arithmetic.
    write_reg(mep_pkg::RegMaxIterations, 31'd0);
    write_reg(mep_pkg::RegStepSize, 31'hFFFFFF);
    write_reg(mep_pkg::RegCenterCol, 31'd0);
    write_reg(mep_pkg::RegCenterRow, 31'd4095);
    write_reg(mep_pkg::RegEscapeLimit, 31'h7FFFFFFF);
    write_reg(mep_pkg::RegInnerLimit, 31'h7FFFFFFF);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();

    write_reg(mep_pkg::RegStepSize, 31'd1);
    write_reg(mep_pkg::RegEscapeLimit, 31'd0);
    write_reg(mep_pkg::RegInnerLimit, 31'd0);
    write_reg(mep_pkg::RegMaxIterations, 31'd3);
    write_reg(mep_pkg::RegCenterCol, 31'd4095);
    write_reg(mep_pkg::RegCenterRow, 31'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd1);
    drain();

    // Wide random pixels at small limits, bursty sender.
    write_reg(mep_pkg::RegStepSize, 31'd20000);
    write_reg(mep_pkg::RegEscapeLimit, 31'd67108864);
    write_reg(mep_pkg::RegInnerLimit, 31'd8388608);
    write_reg(mep_pkg::RegMaxIterations, 31'd20);
    send_burst(200, 1'b1);
    drain();

    // Long receiver hold-off while pixels keep coming, so the block fills.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      send_burst(40, 1'b0);
    join
    drain();

    // Default-like window around the set, varied limits.
    write_reg(mep_pkg::RegCenterCol, 31'd500);
    write_reg(mep_pkg::RegCenterRow, 31'd300);
    write_reg(mep_pkg::RegStepSize, 31'd83886);
    write_reg(mep_pkg::RegEscapeLimit, 31'd167772160);
    write_reg(mep_pkg::RegMaxIterations, 31'd40);
    send_near(150, 400);
    drain();

    write_reg(mep_pkg::RegInnerLimit, 31'd33554432);
    write_reg(mep_pkg::RegMaxIterations, 31'd100);
    send_near(120, 150);
    drain();

    write_reg(mep_pkg::RegMaxIterations, 31'd65535);
    write_reg(mep_pkg::RegStepSize, 31'd8000000);
    send_near(60, 100);
    drain();
    write_reg(mep_pkg::RegStepSize, 31'd4000);
    write_reg(mep_pkg::RegMaxIterations, 31'd1000);
    send_near(4, 3);
    drain();
    repeat (200) @(negedge clk);

    if (sb.errors == 0 && sb.pending_colors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
